// ===== rtl/core/ptw_pkg.sv =====
// Package for the four-level page-table walker.
// Holds the item types, result and command codes and index helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ptw_pkg;

  localparam int unsigned VaW    = 48;
  localparam int unsigned EntryW = 64;
  localparam int unsigned AddrW  = 64;
  localparam int unsigned RootW  = 52;

  typedef enum logic {
    CMD_TRANSLATE = 1'b0,
    CMD_ENTRY     = 1'b1
  } command_e;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_FAULT = 2'd2
  } result_kind_e;

  typedef enum logic [1:0] {
    LVL_ONE   = 2'd0,
    LVL_TWO   = 2'd1,
    LVL_THREE = 2'd2,
    LVL_FOUR  = 2'd3
  } walk_level_e;

  localparam int unsigned BitPresent = 0;
  localparam int unsigned BitLarge   = 7;

  typedef struct packed {
    command_e           command;
    logic [VaW-1:0]     virtual_address;
    logic [EntryW-1:0]  entry_data;
  } in_item_t;

  typedef struct packed {
    result_kind_e       result_kind;
    logic [AddrW-1:0]   result_address;
    logic               large_page;
  } res_item_t;

  // 9-bit table index of the virtual address at a level
  function automatic logic [8:0] level_index(logic [VaW-1:0] va, walk_level_e lvl);
    logic [8:0] idx;
    begin
      unique case (lvl)
        LVL_ONE:   idx = va[47:39];
        LVL_TWO:   idx = va[38:30];
        LVL_THREE: idx = va[29:21];
        LVL_FOUR:  idx = va[20:12];
        default:   idx = va[20:12];
      endcase
      return idx;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/four_level_page_table_walker_top.sv =====
// Four-level page-table walker top level.
// Throughput: one item per cycle while out_stall_i is low; the step logic sits
// between the input register and the result register, walk state updates as each item passes.
// Reset: asynchronous active low; walker idle, root base zero, both regs empty.
// Depends on ptw_pkg, ptw_in_reg, ptw_walk, ptw_out_reg.
`timescale 1ns / 1ps
`default_nettype none

module four_level_page_table_walker_top
  import ptw_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [RootW-1:0]  cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              command_i,
  input  wire logic [VaW-1:0]    virtual_address_i,
  input  wire logic [EntryW-1:0] entry_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [1:0]             result_kind_o,
  output logic [AddrW-1:0]       result_address_o,
  output logic                   large_page_o
);

  in_item_t  in_item, s1_item;
  logic      s1_valid, out_ready, adv, res_valid;
  res_item_t res, out_res;

  assign in_item = '{command: command_e'(command_i),
                     virtual_address: virtual_address_i,
                     entry_data: entry_data_i};

  assign adv = s1_valid & out_ready;

  ptw_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item),
    .adv_i      (adv),
    .in_stall_o (in_stall_o),
    .s1_valid_o (s1_valid),
    .s1_item_o  (s1_item)
  );

  ptw_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (adv),
    .item_i      (s1_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ptw_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv & res_valid),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign result_kind_o    = out_res.result_kind;
  assign result_address_o = out_res.result_address;
  assign large_page_o     = out_res.large_page;

endmodule

`default_nettype wire

// ===== rtl/core/ptw_in_reg.sv =====
// Input register of the walker: captures one item per cycle unless stalled.
// Depends on ptw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptw_in_reg
  import ptw_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire in_item_t in_item_i,
  input  wire logic     adv_i,
  output logic          in_stall_o,
  output logic          s1_valid_o,
  output in_item_t      s1_item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     accept;

  assign in_stall_o = valid_q & ~adv_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_item_o  = item_q;

endmodule

`default_nettype wire

// ===== rtl/core/ptw_walk.sv =====
// Walk state, root base register and the per-item step logic.
// Depends on ptw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptw_walk
  import ptw_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [RootW-1:0] cfg_wdata_i,
  input  wire logic             fire_i,
  input  wire in_item_t         item_i,
  output logic                  res_valid_o,
  output res_item_t             res_o
);

  logic [RootW-1:0] root_q;
  logic             active_q, active_d;
  walk_level_e      level_q, level_d;
  logic [VaW-1:0]   va_q, va_d;
  walk_level_e      lvl_next;

  always_comb begin
    active_d    = active_q;
    level_d     = level_q;
    va_d        = va_q;
    res_valid_o = 1'b0;
    res_o       = '{result_kind: KIND_READ, result_address: '0, large_page: 1'b0};
    lvl_next    = walk_level_e'(level_q + 2'd1);
    if (item_i.command == CMD_TRANSLATE) begin
      va_d        = item_i.virtual_address;
      active_d    = 1'b1;
      level_d     = LVL_ONE;
      res_valid_o = 1'b1;
      res_o.result_address = {12'b0, root_q[51:12],
                              level_index(item_i.virtual_address, LVL_ONE), 3'b000};
    end else if (active_q) begin
      res_valid_o = 1'b1;
      if (level_q == LVL_FOUR) begin
        active_d             = 1'b0;
        level_d              = LVL_ONE;
        res_o.result_kind    = KIND_DONE;
        res_o.result_address = {12'b0, item_i.entry_data[51:12], va_q[11:0]};
      end else if (!item_i.entry_data[BitPresent]) begin
        active_d          = 1'b0;
        level_d           = LVL_ONE;
        res_o.result_kind = KIND_FAULT;
      end else if (level_q == LVL_THREE && item_i.entry_data[BitLarge]) begin
        active_d             = 1'b0;
        level_d              = LVL_ONE;
        res_o.result_kind    = KIND_DONE;
        res_o.result_address = {12'b0, item_i.entry_data[51:21], va_q[20:0]};
        res_o.large_page     = 1'b1;
      end else begin
        level_d              = lvl_next;
        res_o.result_address = {12'b0, item_i.entry_data[51:12],
                                level_index(va_q, lvl_next), 3'b000};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q   <= '0;
      active_q <= 1'b0;
      level_q  <= LVL_ONE;
      va_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        root_q <= cfg_wdata_i;
      end
      if (fire_i) begin
        active_q <= active_d;
        level_q  <= level_d;
        va_q     <= va_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ptw_out_reg.sv =====
// Result register of the walker with valid/stall handshake.
// Depends on ptw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptw_out_reg
  import ptw_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,
  input  wire res_item_t res_i,
  input  wire logic      out_stall_i,
  output logic           ready_o,
  output logic           out_valid_o,
  output res_item_t      res_o
);

  logic      valid_q, valid_d;
  res_item_t res_q;

  assign ready_o = ~valid_q | ~out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire
